// ----- rtl/core/gnms_pkg.sv -----
// Shared types, constants and helpers for the gradient non-maximum suppressor.
package gnms_pkg;

  localparam int CfgW    = 11;
  localparam int PendW   = 12;
  localparam int MagW    = 16;
  localparam int GradW   = 16;
  localparam int QDepth  = 4;
  localparam logic [14:0] TanLo = 15'd27146;
  localparam logic [17:0] TanHi = 18'd158219;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LOW_THRESH   = 2'd2;

  typedef enum logic [1:0] {
    SEC_HORIZ = 2'd0,
    SEC_DIAG  = 2'd1,
    SEC_VERT  = 2'd2,
    SEC_ANTI  = 2'd3
  } sector_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PROD,
    F_SUM,
    F_ROOT,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_EXEC
  } back_state_t;

  typedef struct packed {
    logic             req_type;
    logic signed [GradW-1:0] dx_grad;
    logic signed [GradW-1:0] dy_grad;
  } req_t;

  typedef struct packed {
    logic [MagW-1:0] edge_magnitude;
    logic            last_in_frame;
  } res_t;

  typedef struct packed {
    logic            req_type;
    logic [MagW-1:0] mag;
    sector_t         sec;
  } qent_t;

  typedef struct packed {
    logic [CfgW-1:0] frame_width;
    logic [15:0]     frame_height;
    logic            restart;
  } frame_cfg_t;

  typedef logic [8:0][MagW-1:0] win_t;

  function automatic logic [MagW-1:0] suppress(win_t w, sector_t s);
    logic [MagW-1:0] c, n1, n2;
    c = w[4];
    unique case (s)
      SEC_HORIZ: begin n1 = w[3]; n2 = w[5]; end
      SEC_DIAG:  begin n1 = w[0]; n2 = w[8]; end
      SEC_VERT:  begin n1 = w[1]; n2 = w[7]; end
      SEC_ANTI:  begin n1 = w[2]; n2 = w[6]; end
      default:   begin n1 = '0; n2 = '0; end
    endcase
    return (c == '0 || n1 > c || n2 > c) ? '0 : c;
  endfunction

  function automatic win_t shift_out(win_t w);
    win_t s;
    for (int r = 0; r < 3; r++) begin
      s[r*3]   = w[r*3+1];
      s[r*3+1] = w[r*3+2];
      s[r*3+2] = '0;
    end
    return s;
  endfunction

endpackage

// ----- rtl/core/gnms_front.sv -----
// Front end: takes requests, forms the magnitude by iterative square root and the sector.
module gnms_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  gnms_pkg::req_t         req,
  input  logic [15:0]            low_threshold,
  output logic                   push,
  output gnms_pkg::qent_t        push_data,
  input  logic                   q_full
);
  import gnms_pkg::*;

  front_state_t state, state_next;
  logic        rtype;
  logic [16:0] ax, ay;
  logic        sx, sy;
  logic [31:0] aa, bb, alo;
  logic [34:0] ahi;
  logic [32:0] by;
  logic [32:0] s, root, bitv;
  logic [3:0]  cnt;
  sector_t     sec;
  logic [32:0] trial;
  logic [MagW-1:0] mag;

  assign trial = root + bitv;
  assign mag = (root[15:0] < low_threshold) ? '0 : root[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = (state != F_IDLE);
    push       = 1'b0;
    push_data  = '{req_type: rtype, mag: mag, sec: sec};
    unique case (state)
      F_IDLE: if (req_valid) state_next = F_PROD;
      F_PROD: state_next = F_SUM;
      F_SUM:  state_next = F_ROOT;
      F_ROOT: if (cnt == 4'd15) state_next = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          push       = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        rtype <= req.req_type;
        sx    <= req.dx_grad[GradW-1];
        sy    <= req.dy_grad[GradW-1];
        ax    <= req.dx_grad[GradW-1] ? 17'(-{req.dx_grad[GradW-1], req.dx_grad})
                                      : 17'({1'b0, req.dx_grad});
        ay    <= req.dy_grad[GradW-1] ? 17'(-{req.dy_grad[GradW-1], req.dy_grad})
                                      : 17'({1'b0, req.dy_grad});
      end
      F_PROD: begin
        aa  <= 32'(ax * ax);
        bb  <= 32'(ay * ay);
        alo <= 32'(ax * TanLo);
        ahi <= 35'(ax * TanHi);
        by  <= {ay, 16'd0};
      end
      F_SUM: begin
        s    <= 33'(aa) + 33'(bb);
        root <= '0;
        bitv <= 33'd1 << 30;
        cnt  <= '0;
        if (by <= 33'(alo)) sec <= SEC_HORIZ;
        else if (35'(by) > ahi) sec <= SEC_VERT;
        else sec <= (sx == sy) ? SEC_DIAG : SEC_ANTI;
      end
      F_ROOT: begin
        if (s >= trial) begin
          s    <= s - trial;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 4'd1;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/gnms_queue.sv -----
// Short request queue between front and back ends.
module gnms_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gnms_pkg::qent_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output gnms_pkg::qent_t q_data
);
  import gnms_pkg::*;

  localparam int IW = $clog2(QDepth);
  qent_t         mem [QDepth];
  logic [IW-1:0] wr_ptr, rd_ptr;
  logic [IW:0]   count;

  assign full    = (count == (IW+1)'(QDepth));
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (IW+1)'(push) - (IW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue underflow");

endmodule

// ----- rtl/core/gnms_back.sv -----
// Back end: line buffers, 3x3 window, suppression and frame sequencing.
module gnms_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gnms_pkg::frame_cfg_t fcfg,
  input  logic                 q_valid,
  input  gnms_pkg::qent_t      q_data,
  output logic                 pop,
  output logic                 res_valid,
  input  logic                 res_stall,
  output gnms_pkg::res_t       res
);
  import gnms_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  back_state_t state, state_next;
  logic [MagW-1:0] upper_line  [MAX_WIDTH];
  logic [MagW-1:0] middle_line [MAX_WIDTH];
  sector_t         sector_line [MAX_WIDTH];
  logic [MagW-1:0] upper_rd, middle_rd;
  sector_t         sector_rd, held;
  win_t            win, win_next;
  logic [AW-1:0]   col;
  logic [15:0]     row;
  logic [PendW-1:0] pend;
  logic [CfgW-1:0] w;
  logic [15:0]     h;
  logic            flushing, drop, restart_now, tail_end, out_free;
  logic            emit, wrap, rd_en, exec_go, tail_go, load_res;
  logic [MagW-1:0] mag, top, mid, result;

  always_comb begin
    if (fcfg.frame_width == '0) w = CfgW'(1);
    else if (32'(fcfg.frame_width) > MAX_WIDTH) w = CfgW'(MAX_WIDTH);
    else w = fcfg.frame_width;
    h = (fcfg.frame_height == '0) ? 16'd1 : fcfg.frame_height;
  end

  assign flushing    = (pend != '0);
  assign out_free    = !res_valid || !res_stall;
  assign drop        = !flushing && q_data.req_type;
  assign restart_now = (32'(col) >= 32'(w)) || (!flushing && row >= h);
  assign tail_end    = (pend == PendW'(1));
  assign emit        = (row >= 16'd2) || (row == 16'd1 && col != '0);
  assign wrap        = (32'(col) + 1 >= 32'(w));
  assign mag         = flushing ? '0 : q_data.mag;
  assign top         = (row >= 16'd2) ? upper_rd : '0;
  assign mid         = (row >= 16'd1) ? middle_rd : '0;
  assign load_res    = !fcfg.restart && (tail_go || (exec_go && emit));

  always_comb begin
    win_next = win;
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]   = (col == '0) ? '0 : win[r*3+1];
      win_next[r*3+1] = (col == '0) ? '0 : win[r*3+2];
    end
    win_next[2] = top;
    win_next[5] = mid;
    win_next[8] = mag;
    result = (col == '0) ? suppress(shift_out(win), held) : suppress(win_next, held);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    rd_en      = 1'b0;
    exec_go    = 1'b0;
    tail_go    = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (q_valid && !fcfg.restart) begin
          priority if (drop) begin
            pop = 1'b1;
          end else if (restart_now) begin
          end else if (tail_end) begin
            if (out_free) begin
              tail_go = 1'b1;
              pop     = 1'b1;
            end
          end else begin
            rd_en      = 1'b1;
            state_next = B_READ;
          end
        end
      end
      B_READ: state_next = B_EXEC;
      B_EXEC: begin
        if (out_free) begin
          exec_go    = 1'b1;
          pop        = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_rd  <= upper_line[col];
      middle_rd <= middle_line[col];
      sector_rd <= sector_line[col];
    end
    if (exec_go) begin
      upper_line[col]  <= middle_rd;
      middle_line[col] <= mag;
      if (!flushing) sector_line[col] <= q_data.sec;
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      pend      <= '0;
      held      <= SEC_HORIZ;
      res_valid <= 1'b0;
    end else begin
      if (load_res) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
      if (fcfg.restart) begin
        col  <= '0;
        row  <= '0;
        pend <= '0;
      end else if (state == B_IDLE && q_valid && !drop && restart_now) begin
        col  <= '0;
        row  <= '0;
        pend <= '0;
      end else if (tail_go) begin
        res  <= '{edge_magnitude: suppress(shift_out(win), held), last_in_frame: 1'b1};
        col  <= '0;
        row  <= '0;
        pend <= '0;
      end else if (exec_go) begin
        held <= sector_rd;
        if (emit) begin
          res <= '{edge_magnitude: result, last_in_frame: 1'b0};
        end
        if (flushing) begin
          pend <= pend - 1'b1;
          col  <= wrap ? '0 : col + 1'b1;
        end else if (wrap) begin
          col <= '0;
          row <= row + 16'd1;
          if (32'(row) + 1 >= 32'(h)) pend <= PendW'(w) + PendW'(1);
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pend) <= MAX_WIDTH + 1)
    else $error("pending count out of range");
  a_tail_clears: assert property (@(posedge clk) disable iff (rst)
    tail_go && !fcfg.restart |=> pend == '0 && col == '0 && row == '0)
    else $error("frame tail did not restart");
  a_exec_after_read: assert property (@(posedge clk) disable iff (rst)
    state == B_READ |=> state == B_EXEC)
    else $error("read not followed by execute");

endmodule

// ----- rtl/core/gradient_nonmaxima_suppressor_top.sv -----
// Top level of the gradient non-maximum suppressor: config registers and front/queue/back.
// Each gradient pixel passes the 16-step square-root iteration in the front end, which
// takes no new pixel before pushing the current one; the back end does one line-buffer
// read and one write a pixel. Results lag one row plus one pixel, and after a frame's last
// pixel frame_width+1 further requests (drain ticks) flush the tail, the last result
// flagged last_in_frame. Drain ticks outside a tail are ignored. Writing frame_width
// or frame_height restarts the frame. No clearing pass is needed after reset.
module gradient_nonmaxima_suppressor_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  gnms_pkg::req_t   req,
  output logic             res_valid,
  input  logic             res_stall,
  output gnms_pkg::res_t   res,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import gnms_pkg::*;

  logic [CfgW-1:0] frame_width;
  logic [15:0]     frame_height;
  logic [15:0]     low_threshold;
  logic            restart;
  frame_cfg_t      fcfg;
  logic            push, full, pop, q_valid;
  qent_t           push_data, q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= CfgW'(640);
      frame_height  <= 16'd480;
      low_threshold <= 16'd0;
      restart       <= 1'b0;
    end else begin
      restart <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH: begin
            frame_width <= cfg_data[CfgW-1:0];
            restart     <= 1'b1;
          end
          REG_FRAME_HEIGHT: begin
            frame_height <= cfg_data;
            restart      <= 1'b1;
          end
          REG_LOW_THRESH: low_threshold <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign fcfg = '{frame_width: frame_width, frame_height: frame_height, restart: restart};

  gnms_front u_front (
    .clk, .rst, .req_valid, .req_stall, .req, .low_threshold,
    .push, .push_data, .q_full(full)
  );

  gnms_queue u_queue (
    .clk, .rst, .push, .push_data, .full, .pop, .q_valid, .q_data
  );

  gnms_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk, .rst, .fcfg, .q_valid, .q_data, .pop, .res_valid, .res_stall, .res
  );

endmodule
